// ===== rtl/jpeg_dequant_idct_block_macros.svh =====
// Assertion helpers included by the top-level RTL file.
`ifndef JPEG_DEQUANT_IDCT_BLOCK_MACROS_SVH
`define JPEG_DEQUANT_IDCT_BLOCK_MACROS_SVH

// Check a property on every clock edge outside reset.
`define JDI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define JDI_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== rtl/jdi_pkg.sv =====
package jdi_pkg;

   typedef struct packed {
      logic              func;
      logic [5:0]        position;
      logic signed [11:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic [5:0] pixel_index;
      logic       last;
   } rsp_type;

   // Beat traveling down the cell chain.
   typedef struct packed {
      logic       valid;
      logic [2:0] tag;
   } ctl_type;

   localparam logic FUNC_QUANT = 1'b0;
   localparam logic FUNC_COEF  = 1'b1;

   localparam int HI_FRAC_BITS = 30;
   localparam longint INV_SQRT2_HI = 759250125;
   localparam longint COS_HI [0:8] = '{
      1073741824, 1053110176, 992008094, 892783698, 759250125,
      596538995, 410903207, 209476638, 0
   };

   localparam logic [5:0] ZIG_TO_NAT [0:63] = '{
       0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
      12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
      35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
      58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
   };

   // c(u) * cos((2t+1) u pi / 16) at 2^frac, rounded half away from zero.
   function automatic logic signed [31:0] cos_term(input logic [2:0] u,
                                                   input logic [2:0] t,
                                                   input int frac);
      int     kk;
      int     sh;
      logic   neg;
      longint base;
      longint mag;
      neg = 1'b0;
      sh  = HI_FRAC_BITS - frac;
      kk  = ((2 * int'(t) + 1) * int'(u)) & 31;
      if (kk > 16) kk = 32 - kk;
      if (kk > 8) begin
         kk  = 16 - kk;
         neg = 1'b1;
      end
      base = (u == 3'd0) ? INV_SQRT2_HI : COS_HI[kk];
      mag  = (base + (64'sd1 <<< (sh - 1))) >>> sh;
      return neg ? 32'(-mag) : 32'(mag);
   endfunction

endpackage

// ===== rtl/jdi_cell.sv =====
module jdi_cell #(
   parameter int DW       = 37,
   parameter int KW       = 16,
   parameter int AW       = 54,
   parameter int FRAC     = 14,
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  jdi_pkg::ctl_type      in_ctl,
   input  logic signed [DW-1:0]  in_data,
   output jdi_pkg::ctl_type      out_ctl,
   output logic signed [DW-1:0]  out_data,
   output logic                  done,
   output logic signed [AW-1:0]  result
);
   import jdi_pkg::*;

   localparam int PW = DW + KW;
   localparam logic [2:0] IDX = 3'(CELL_IDX);

   ctl_type              ctl_ff;
   logic signed [DW-1:0] data_ff;
   logic                 pv_ff;
   logic [2:0]           pt_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [KW-1:0] kterm;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] acc_in;
   logic                 done_ff;

   assign kterm   = KW'(cos_term(ctl_ff.tag, IDX, FRAC));
   assign prod_in = data_ff * kterm;
   // restart the sum on tag zero
   assign acc_in  = ((pt_ff == 3'd0) ? '0 : acc_ff) + AW'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else if (adv) begin
         ctl_ff  <= in_ctl;
         pv_ff   <= ctl_ff.valid;
         done_ff <= pv_ff && (pt_ff == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= in_data;
         pt_ff   <= ctl_ff.tag;
         prod_ff <= prod_in;
         if (pv_ff) acc_ff <= acc_in;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_data = data_ff;
   assign done     = done_ff;
   assign result   = acc_ff;

endmodule

// ===== rtl/jpeg_dequant_idct_block.sv =====
// Channel   Ports                          Beat
// --------  -----------------------------  --------------------------------
// input     req_valid req_stall req_data   func, zigzag position, value
// output    rsp_valid rsp_stall rsp_data   pixel, pixel_index, last
//
// A table entry or a coefficient below position 63 leaves req_stall low.
// Position 63 runs two passes of 64 beats down an eight-cell MAC chain. Pass
// one drains into the partial-sum table before pass two starts; req_stall
// stays high until the last pixel of pass two leaves, including every cycle a
// pixel waits on rsp_stall, which freezes the whole transform pipeline.
// Reset is synchronous; the tables hold no reset.
module jpeg_dequant_idct_block #(
   parameter int COS_FRAC_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jdi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jdi_pkg::rsp_type rsp_data
);
   import jdi_pkg::*;
   `include "jpeg_dequant_idct_block_macros.svh"

   localparam int KW = COS_FRAC_BITS + 2;
   localparam int SW = COS_FRAC_BITS + 23;
   localparam int TW = 2 * COS_FRAC_BITS + 26;
   localparam int SH = 2 * COS_FRAC_BITS + 2;
   localparam int RW = TW - SH;
   localparam logic [TW-1:0] HALF = TW'(1) << (SH - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DQ   = 3'd1;
   localparam logic [2:0] ST_P1   = 3'd2;
   localparam logic [2:0] ST_W1   = 3'd3;
   localparam logic [2:0] ST_P2   = 3'd4;
   localparam logic [2:0] ST_W2   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       adv;
   logic       req_acc;
   logic       rsp_acc;
   logic       phase2;

   logic [7:0]         qmem [0:63];
   logic signed [19:0] cmem [0:63];
   logic signed [SW-1:0] smem [0:63];

   logic               dq_valid_ff;
   logic [5:0]         dq_pos_ff;
   logic signed [11:0] dq_val_ff;
   logic [7:0]         q_rd_ff;
   logic signed [19:0] dq_prod;

   logic                 iss_valid_ff;
   logic [2:0]           iss_tag_ff;
   logic                 iss_p2_ff;
   logic signed [19:0]   cmem_rd_ff;
   logic signed [SW-1:0] smem_rd_ff;

   ctl_type              chain_ctl  [0:8];
   logic signed [SW-1:0] chain_data [0:8];
   logic [7:0]           done_vec;
   logic signed [TW-1:0] cell_res [0:7];
   logic signed [TW-1:0] done_data;
   logic                 done_any;

   logic [5:0]           wcnt_ff;
   logic                 tr_valid_ff;
   logic signed [TW-1:0] tr_ff;
   logic [5:0]           pix_cnt_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 tr_neg;
   logic [TW-1:0]        tr_mag;
   logic [TW-1:0]        tr_rsum;
   logic [RW-1:0]        tr_rq;
   logic signed [RW+1:0] samp;
   logic [7:0]           pix;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;
   assign phase2    = (state_ff == ST_P2) || (state_ff == ST_W2);

   // Dequantize: table read on accept, multiply and store next cycle.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (req_data.func == FUNC_QUANT) qmem[req_data.position] <= req_data.value[7:0];
         q_rd_ff   <= qmem[req_data.position];
         dq_pos_ff <= req_data.position;
         dq_val_ff <= req_data.value;
      end
   end

   assign dq_prod = dq_val_ff * $signed({1'b0, q_rd_ff});

   always_ff @(posedge clock) begin
      if (reset) dq_valid_ff <= 1'b0;
      else       dq_valid_ff <= req_acc && (req_data.func == FUNC_COEF);
   end

   always_ff @(posedge clock) begin
      if (dq_valid_ff) cmem[ZIG_TO_NAT[dq_pos_ff]] <= dq_prod;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.func == FUNC_COEF) && (req_data.position == 6'd63))
               state_in = ST_DQ;
         end
         ST_DQ: begin
            state_in = ST_P1;
            cnt_in   = '0;
         end
         ST_P1: begin
            if (adv) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) state_in = ST_W1;
            end
         end
         ST_W1: begin
            if (adv && done_any && (wcnt_ff == 6'd63)) begin
               state_in = ST_P2;
               cnt_in   = '0;
            end
         end
         ST_P2: begin
            if (adv) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) state_in = ST_W2;
            end
         end
         ST_W2: begin
            if (rsp_acc && rsp_ff.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         iss_valid_ff <= 1'b0;
         wcnt_ff      <= '0;
         tr_valid_ff  <= 1'b0;
         pix_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (adv) begin
            iss_valid_ff <= (state_ff == ST_P1) || (state_ff == ST_P2);
            if (done_any && !phase2) wcnt_ff <= wcnt_ff + 6'd1;
            tr_valid_ff  <= done_any && phase2;
            rsp_valid_ff <= tr_valid_ff;
            if (tr_valid_ff) pix_cnt_ff <= pix_cnt_ff + 6'd1;
         end
      end
   end

   // Pass one streams columns of coefficients, pass two rows of partial sums.
   always_ff @(posedge clock) begin
      if (adv) begin
         iss_tag_ff <= cnt_ff[2:0];
         iss_p2_ff  <= (state_ff == ST_P2);
         if (state_ff == ST_P1) cmem_rd_ff <= cmem[{cnt_ff[2:0], cnt_ff[5:3]}];
         if (state_ff == ST_P2) smem_rd_ff <= smem[cnt_ff];
         if (done_any && !phase2) smem[{wcnt_ff[2:0], wcnt_ff[5:3]}] <= done_data[SW-1:0];
         if (done_any && phase2) tr_ff <= done_data;
      end
   end

   assign chain_ctl[0]  = '{valid: iss_valid_ff, tag: iss_tag_ff};
   assign chain_data[0] = iss_p2_ff ? smem_rd_ff : SW'(cmem_rd_ff);

   for (genvar gi = 0; gi < 8; gi++) begin : g_cell
      jdi_cell #(
         .DW       (SW),
         .KW       (KW),
         .AW       (TW),
         .FRAC     (COS_FRAC_BITS),
         .CELL_IDX (gi)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_ctl   (chain_ctl[gi]),
         .in_data  (chain_data[gi]),
         .out_ctl  (chain_ctl[gi+1]),
         .out_data (chain_data[gi+1]),
         .done     (done_vec[gi]),
         .result   (cell_res[gi])
      );
   end

   // Cells finish on distinct cycles, so an OR of gated sums picks the one.
   always_comb begin
      done_data = '0;
      for (int i = 0; i < 8; i++) begin
         if (done_vec[i]) done_data = done_data | cell_res[i];
      end
   end
   assign done_any = |done_vec;

   // Round half away from zero, level shift, clamp.
   always_comb begin
      tr_neg  = tr_ff[TW-1];
      tr_mag  = tr_neg ? TW'(-tr_ff) : TW'(tr_ff);
      tr_rsum = tr_mag + HALF;
      tr_rq   = tr_rsum[TW-1:SH];
      samp    = tr_neg ? -$signed({2'b00, tr_rq}) : $signed({2'b00, tr_rq});
      samp    = samp + (RW+2)'(128);
      if (samp < 0)                 pix = 8'd0;
      else if (samp > (RW+2)'(255)) pix = 8'd255;
      else                          pix = samp[7:0];
   end

   always_ff @(posedge clock) begin
      if (adv && tr_valid_ff) begin
         rsp_ff.pixel       <= pix;
         rsp_ff.pixel_index <= pix_cnt_ff;
         rsp_ff.last        <= (pix_cnt_ff == 6'd63);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `JDI_ASSERT(a_one_done, $onehot0(done_vec), "two cells finished in one cycle")
   `JDI_ASSERT_NEXT(a_last_idle, rsp_acc && rsp_ff.last, state_ff == ST_IDLE, "no idle after last")
   `JDI_ASSERT(a_p1_no_sample, (state_ff == ST_P1) |-> !tr_valid_ff, "sample during pass one")

endmodule
